// ===== hw/rtl/sfc_pkg.sv =====
`default_nettype none

package sfc_pkg;

  localparam int MAX_SEGMENTS = 32;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int ADDR_W       = 16;
  localparam int LEN_W        = ADDR_W + 1;
  localparam int OWNER_W      = 8;

  localparam logic [LEN_W-1:0] MEM_LIMIT = LEN_W'(1) << ADDR_W;
  localparam logic [LEN_W-1:0] MEM_SIZE_RESET = MEM_LIMIT;
  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SEGMENTS);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_FREE   = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  typedef struct packed {
    logic               busy;
    logic [OWNER_W-1:0] owner;
    logic [LEN_W-1:0]   length;
    logic [ADDR_W-1:0]  base;
  } entry_t;

  typedef enum logic [11:0] {
    ST_INIT = 12'b0000_0000_0001,
    ST_IDLE = 12'b0000_0000_0010,
    ST_SCAN = 12'b0000_0000_0100,
    ST_FCHK = 12'b0000_0000_1000,
    ST_PREV = 12'b0000_0001_0000,
    ST_PCHK = 12'b0000_0010_0000,
    ST_NEXT = 12'b0000_0100_0000,
    ST_NCHK = 12'b0000_1000_0000,
    ST_WRLO = 12'b0001_0000_0000,
    ST_SHRD = 12'b0010_0000_0000,
    ST_SHWR = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/segment_free_with_coalescing_core.sv =====
`default_nettype none
// Segment table with free and coalescing. Clear, append and unused commands go straight from
// idle to the done state. Free scans for the first busy entry of the owner, checks the previous
// and next neighbors, writes the merged segment at the lowest merged slot, then shifts the later
// entries down by the gap. One word is in flight; the next can be accepted as out_valid rises,
// later while out_ready stalls hold the result in the done state.
// Synchronous reset (rst_n low) sets memory_size 65536, count one; the init state writes entry 0.
module segment_free_with_coalescing_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic [sfc_pkg::OWNER_W-1:0] in_process_id,
  input  wire logic [sfc_pkg::ADDR_W-1:0]  in_seg_base,
  input  wire logic [sfc_pkg::LEN_W-1:0]   in_seg_length,
  input  wire logic                        in_seg_occupied,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [sfc_pkg::ADDR_W-1:0]       out_merged_base,
  output logic [sfc_pkg::LEN_W-1:0]        out_merged_length,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [sfc_pkg::LEN_W-1:0]   cfg_wdata
);

  // Sequencer state
  sfc_pkg::state_t                st_r, st_nxt;
  logic [sfc_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;     // live entries
  logic [sfc_pkg::CNT_W-1:0]      idx_r, idx_nxt;     // scan pointer
  logic [sfc_pkg::CNT_W-1:0]      k_r, k_nxt;         // shift pointer
  logic [sfc_pkg::IDX_W-1:0]      i_r, i_nxt;         // found entry
  logic [sfc_pkg::IDX_W-1:0]      lo_r, lo_nxt;
  logic [sfc_pkg::IDX_W-1:0]      hi_r, hi_nxt;
  logic [1:0]                     gap_r, gap_nxt;
  logic [sfc_pkg::OWNER_W-1:0]    pid_r, pid_nxt;
  logic [sfc_pkg::ADDR_W-1:0]     mbase_r, mbase_nxt;
  logic [sfc_pkg::LEN_W-1:0]      mlen_r, mlen_nxt;
  logic [1:0]                     stat_r, stat_nxt;
  logic [sfc_pkg::LEN_W-1:0]      mem_size_r;

  // Output register, parts the result channel from the sequencer
  logic                           out_valid_r, out_valid_nxt;
  logic [1:0]                     out_status_r, out_status_nxt;
  logic [sfc_pkg::ADDR_W-1:0]     out_base_r, out_base_nxt;
  logic [sfc_pkg::LEN_W-1:0]      out_len_r, out_len_nxt;

  // Segment table: one write port, one registered read port
  sfc_pkg::entry_t                mem [sfc_pkg::MAX_SEGMENTS];
  sfc_pkg::entry_t                rd_data_r;
  logic [sfc_pkg::IDX_W-1:0]      rd_addr;
  logic                           mem_we;
  logic [sfc_pkg::IDX_W-1:0]      mem_waddr;
  sfc_pkg::entry_t                mem_wdata;

  // Shared saturating length adder, used for both neighbor merges
  logic [sfc_pkg::LEN_W:0]        sum_wide;
  logic [sfc_pkg::LEN_W-1:0]      len_sum;
  logic [sfc_pkg::LEN_W-1:0]      clear_len;
  sfc_pkg::entry_t                clear_entry;

  assign sum_wide = {1'b0, mlen_r} + {1'b0, rd_data_r.length};
  assign len_sum  = sum_wide[sfc_pkg::LEN_W] ? '1 : sum_wide[sfc_pkg::LEN_W-1:0];

  // Clear saturates the configured size at the address space
  assign clear_len = (mem_size_r > sfc_pkg::MEM_LIMIT) ? sfc_pkg::MEM_LIMIT : mem_size_r;
  assign clear_entry = '{busy: 1'b0, owner: '0, length: clear_len, base: '0};

  assign in_ready          = (st_r == sfc_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_merged_base   = out_base_r;
  assign out_merged_length = out_len_r;

  always_comb begin
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    gap_nxt        = gap_r;
    pid_nxt        = pid_r;
    mbase_nxt      = mbase_r;
    mlen_nxt       = mlen_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_base_nxt   = out_base_r;
    out_len_nxt    = out_len_r;
    rd_addr        = '0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = clear_entry;

    case (st_r)
      sfc_pkg::ST_INIT: begin
        // write entry 0 as the single free segment
        mem_we = 1'b1;
        st_nxt = sfc_pkg::ST_IDLE;
      end

      sfc_pkg::ST_IDLE: begin
        if (in_valid) begin
          pid_nxt   = in_process_id;
          mbase_nxt = '0;
          mlen_nxt  = '0;
          stat_nxt  = sfc_pkg::STAT_OK;
          st_nxt    = sfc_pkg::ST_DONE;
          case (in_cmd)
            sfc_pkg::CMD_CLEAR: begin
              mem_we  = 1'b1;
              cnt_nxt = sfc_pkg::CNT_W'(1);
            end
            sfc_pkg::CMD_APPEND: begin
              if (cnt_r >= sfc_pkg::MAX_COUNT) begin
                stat_nxt = sfc_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[sfc_pkg::IDX_W-1:0];
                mem_wdata = '{busy: in_seg_occupied, owner: in_process_id,
                              length: in_seg_length, base: in_seg_base};
                cnt_nxt   = cnt_r + sfc_pkg::CNT_W'(1);
              end
            end
            sfc_pkg::CMD_FREE: begin
              idx_nxt = '0;
              st_nxt  = sfc_pkg::ST_SCAN;
            end
            default: begin
              st_nxt = sfc_pkg::ST_DONE;
            end
          endcase
        end
      end

      sfc_pkg::ST_SCAN: begin
        if (idx_r >= cnt_r) begin
          stat_nxt = sfc_pkg::STAT_NOTFOUND;
          st_nxt   = sfc_pkg::ST_DONE;
        end else begin
          rd_addr = idx_r[sfc_pkg::IDX_W-1:0];
          st_nxt  = sfc_pkg::ST_FCHK;
        end
      end

      sfc_pkg::ST_FCHK: begin
        if (rd_data_r.busy && (rd_data_r.owner == pid_r)) begin
          i_nxt     = idx_r[sfc_pkg::IDX_W-1:0];
          lo_nxt    = idx_r[sfc_pkg::IDX_W-1:0];
          hi_nxt    = idx_r[sfc_pkg::IDX_W-1:0];
          mbase_nxt = rd_data_r.base;
          mlen_nxt  = rd_data_r.length;
          st_nxt    = sfc_pkg::ST_PREV;
        end else begin
          idx_nxt = idx_r + sfc_pkg::CNT_W'(1);
          st_nxt  = sfc_pkg::ST_SCAN;
        end
      end

      sfc_pkg::ST_PREV: begin
        if (i_r != '0) begin
          rd_addr = i_r - sfc_pkg::IDX_W'(1);
          st_nxt  = sfc_pkg::ST_PCHK;
        end else begin
          st_nxt = sfc_pkg::ST_NEXT;
        end
      end

      sfc_pkg::ST_PCHK: begin
        if (!rd_data_r.busy) begin
          lo_nxt    = i_r - sfc_pkg::IDX_W'(1);
          mbase_nxt = rd_data_r.base;
          mlen_nxt  = len_sum;
        end
        st_nxt = sfc_pkg::ST_NEXT;
      end

      sfc_pkg::ST_NEXT: begin
        if (({1'b0, i_r} + sfc_pkg::CNT_W'(1)) < cnt_r) begin
          rd_addr = i_r + sfc_pkg::IDX_W'(1);
          st_nxt  = sfc_pkg::ST_NCHK;
        end else begin
          st_nxt = sfc_pkg::ST_WRLO;
        end
      end

      sfc_pkg::ST_NCHK: begin
        if (!rd_data_r.busy) begin
          hi_nxt   = i_r + sfc_pkg::IDX_W'(1);
          mlen_nxt = len_sum;
        end
        st_nxt = sfc_pkg::ST_WRLO;
      end

      sfc_pkg::ST_WRLO: begin
        // store the merged free segment at the lowest merged slot
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = '{busy: 1'b0, owner: '0, length: mlen_r, base: mbase_r};
        gap_nxt   = 2'(hi_r - lo_r);
        k_nxt     = {1'b0, hi_r} + sfc_pkg::CNT_W'(1);
        st_nxt    = (hi_r == lo_r) ? sfc_pkg::ST_DONE : sfc_pkg::ST_SHRD;
      end

      sfc_pkg::ST_SHRD: begin
        if (k_r >= cnt_r) begin
          cnt_nxt = cnt_r - sfc_pkg::CNT_W'(gap_r);
          st_nxt  = sfc_pkg::ST_DONE;
        end else begin
          rd_addr = k_r[sfc_pkg::IDX_W-1:0];
          st_nxt  = sfc_pkg::ST_SHWR;
        end
      end

      sfc_pkg::ST_SHWR: begin
        // move entry k down by the gap
        mem_we    = 1'b1;
        mem_waddr = sfc_pkg::IDX_W'(k_r - sfc_pkg::CNT_W'(gap_r));
        mem_wdata = rd_data_r;
        k_nxt     = k_r + sfc_pkg::CNT_W'(1);
        st_nxt    = sfc_pkg::ST_SHRD;
      end

      sfc_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_base_nxt   = mbase_r;
          out_len_nxt    = mlen_r;
          st_nxt         = sfc_pkg::ST_IDLE;
        end
      end

      default: begin
        st_nxt = sfc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= sfc_pkg::ST_INIT;
      cnt_r       <= sfc_pkg::CNT_W'(1);
      out_valid_r <= 1'b0;
      mem_size_r  <= sfc_pkg::MEM_SIZE_RESET;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mem_size_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    i_r          <= i_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    gap_r        <= gap_nxt;
    pid_r        <= pid_nxt;
    mbase_r      <= mbase_nxt;
    mlen_r       <= mlen_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
    out_base_r   <= out_base_nxt;
    out_len_r    <= out_len_nxt;
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= sfc_pkg::MAX_COUNT))
    else $error("entry count out of range");

  a_shift_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == sfc_pkg::ST_SHWR) |-> ((gap_r != 2'd0) && (k_r < cnt_r)))
    else $error("shift step without gap or past the table end");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is in progress");

  a_merge_span: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == sfc_pkg::ST_WRLO) |-> ((lo_r <= i_r) && (hi_r >= i_r)
      && (5'(hi_r - lo_r) <= 5'd2)))
    else $error("merge span inconsistent with found entry");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // cmd code 3 has no name in the package; the block must answer it with ok and zeros
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         RANDOM_WORDS = 1200;
  localparam int         POOL_SIZE    = 5;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic [sfc_pkg::OWNER_W-1:0] pid;
    logic [sfc_pkg::ADDR_W-1:0]  base;
    logic [sfc_pkg::LEN_W-1:0]   length;
    logic                        occupied;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [sfc_pkg::ADDR_W-1:0] merged_base;
    logic [sfc_pkg::LEN_W-1:0]  merged_length;
  } seg_result_t;

  logic                        clk;
  logic                        rst_n           = 1'b0;
  logic                        in_valid        = 1'b0;
  logic                        in_ready;
  logic [1:0]                  in_cmd          = sfc_pkg::CMD_CLEAR;
  logic [sfc_pkg::OWNER_W-1:0] in_process_id   = '0;
  logic [sfc_pkg::ADDR_W-1:0]  in_seg_base     = '0;
  logic [sfc_pkg::LEN_W-1:0]   in_seg_length   = '0;
  logic                        in_seg_occupied = 1'b0;
  logic                        out_valid;
  logic                        out_ready       = 1'b0;
  logic [1:0]                  out_status;
  logic [sfc_pkg::ADDR_W-1:0]  out_merged_base;
  logic [sfc_pkg::LEN_W-1:0]   out_merged_length;
  logic                        cfg_we          = 1'b0;
  logic [sfc_pkg::LEN_W-1:0]   cfg_wdata       = '0;

  segment_free_with_coalescing_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_process_id     (in_process_id),
    .in_seg_base       (in_seg_base),
    .in_seg_length     (in_seg_length),
    .in_seg_occupied   (in_seg_occupied),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_merged_base   (out_merged_base),
    .out_merged_length (out_merged_length),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Segment table as the testbench sees it: one copy, updated at each accepted
  // input word, in the order the block accepts them.
  // ---------------------------------------------------------------------------
  logic [sfc_pkg::ADDR_W-1:0]  tbl_base   [sfc_pkg::MAX_SEGMENTS];
  logic [sfc_pkg::LEN_W-1:0]   tbl_length [sfc_pkg::MAX_SEGMENTS];
  logic                        tbl_busy   [sfc_pkg::MAX_SEGMENTS];
  logic [sfc_pkg::OWNER_W-1:0] tbl_owner  [sfc_pkg::MAX_SEGMENTS];
  int                          tbl_count;
  logic [sfc_pkg::LEN_W-1:0]   tbl_mem_size;

  // Results owed by the block, oldest first
  seg_result_t expected_results[$];

  int fail_count = 0;
  int words_sent = 0;
  int stall_left = 0;
  bit steady     = 1'b0;  // when set, neither side idles

  // Reset the table to a single free segment spanning memory, clamped to the address space
  function automatic void table_clear();
    logic [sfc_pkg::LEN_W-1:0] size;
    size = (tbl_mem_size > sfc_pkg::MEM_LIMIT) ? sfc_pkg::MEM_LIMIT : tbl_mem_size;
    for (int k = 0; k < sfc_pkg::MAX_SEGMENTS; k++) begin
      tbl_base[k]   = '0;
      tbl_length[k] = '0;
      tbl_busy[k]   = 1'b0;
      tbl_owner[k]  = '0;
    end
    tbl_length[0] = size;
    tbl_count     = 1;
  endfunction

  // Add two lengths, clamping at the all-ones length
  function automatic logic [sfc_pkg::LEN_W-1:0] length_sum(
      input logic [sfc_pkg::LEN_W-1:0] a, input logic [sfc_pkg::LEN_W-1:0] b);
    logic [sfc_pkg::LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[sfc_pkg::LEN_W] ? {sfc_pkg::LEN_W{1'b1}} : s[sfc_pkg::LEN_W-1:0];
  endfunction

  // Apply one command word to the table and return the result word it owes
  function automatic seg_result_t segment_table_update(input cmd_word_t w);
    seg_result_t r;
    int hit, lo, hi, gap;
    r = '0;
    case (w.cmd)
      sfc_pkg::CMD_CLEAR: begin
        table_clear();
      end
      sfc_pkg::CMD_APPEND: begin
        if (tbl_count >= sfc_pkg::MAX_SEGMENTS) begin
          r.status = sfc_pkg::STAT_FULL;
        end else begin
          tbl_base[tbl_count]   = w.base;
          tbl_length[tbl_count] = w.length;
          tbl_busy[tbl_count]   = w.occupied;
          tbl_owner[tbl_count]  = w.pid;
          tbl_count++;
        end
      end
      sfc_pkg::CMD_FREE: begin
        // first busy entry of this owner wins
        hit = tbl_count;
        for (int k = tbl_count - 1; k >= 0; k--)
          if (tbl_busy[k] && tbl_owner[k] == w.pid) hit = k;
        if (hit == tbl_count) begin
          r.status = sfc_pkg::STAT_NOTFOUND;
        end else begin
          lo              = hit;
          hi              = hit;
          r.merged_base   = tbl_base[hit];
          r.merged_length = tbl_length[hit];
          if (hit > 0 && !tbl_busy[hit-1]) begin
            lo              = hit - 1;
            r.merged_base   = tbl_base[lo];
            r.merged_length = length_sum(r.merged_length, tbl_length[lo]);
          end
          if (hit + 1 < tbl_count && !tbl_busy[hit+1]) begin
            hi              = hit + 1;
            r.merged_length = length_sum(r.merged_length, tbl_length[hi]);
          end
          tbl_base[lo]   = r.merged_base;
          tbl_length[lo] = r.merged_length;
          tbl_busy[lo]   = 1'b0;
          tbl_owner[lo]  = '0;
          // close the hole left by absorbed neighbors
          gap = hi - lo;
          if (gap > 0) begin
            for (int k = hi + 1; k < tbl_count; k++) begin
              tbl_base[k-gap]   = tbl_base[k];
              tbl_length[k-gap] = tbl_length[k];
              tbl_busy[k-gap]   = tbl_busy[k];
              tbl_owner[k-gap]  = tbl_owner[k];
            end
            for (int k = tbl_count - gap; k < tbl_count; k++) begin
              tbl_base[k]   = '0;
              tbl_length[k] = '0;
              tbl_busy[k]   = 1'b0;
              tbl_owner[k]  = '0;
            end
            tbl_count -= gap;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Segment length: favor small sizes, keep both ends of the range in play
  function automatic logic [sfc_pkg::LEN_W-1:0] random_length();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return sfc_pkg::MEM_LIMIT;
    if (r == 1) return sfc_pkg::LEN_W'(1);
    if (r == 2) return sfc_pkg::LEN_W'($urandom_range(1, 65536));
    return sfc_pkg::LEN_W'($urandom_range(1, 4096));
  endfunction

  function automatic logic [sfc_pkg::LEN_W-1:0] random_mem_size();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return sfc_pkg::LEN_W'(1);
      2:       return sfc_pkg::MEM_LIMIT;
      3:       return {sfc_pkg::LEN_W{1'b1}};
      4:       return sfc_pkg::LEN_W'($urandom_range(1, 65536));
      default: return sfc_pkg::LEN_W'($urandom_range(0, 131071));
    endcase
  endfunction

  function automatic cmd_word_t word_of(input logic [1:0]                  cmd,
                                        input logic [sfc_pkg::OWNER_W-1:0] pid,
                                        input logic [sfc_pkg::ADDR_W-1:0]  base,
                                        input logic [sfc_pkg::LEN_W-1:0]   length,
                                        input logic                        occupied);
    cmd_word_t w;
    w.cmd      = cmd;
    w.pid      = pid;
    w.base     = base;
    w.length   = length;
    w.occupied = occupied;
    return w;
  endfunction

  function automatic cmd_word_t random_word();
    return word_of(2'($urandom_range(0, 3)), sfc_pkg::OWNER_W'($urandom),
                   sfc_pkg::ADDR_W'($urandom), sfc_pkg::LEN_W'($urandom_range(1, 65536)),
                   1'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Present one word, hold it until accepted, then maybe drop valid for a while.
  // Valid stays high across back-to-back words so it is never lowered and raised
  // at the same edge.
  task automatic send_word(input cmd_word_t w);
    int gap;
    in_valid        <= 1'b1;
    in_cmd          <= w.cmd;
    in_process_id   <= w.pid;
    in_seg_base     <= w.base;
    in_seg_length   <= w.length;
    in_seg_occupied <= w.occupied;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(segment_table_update(w));
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Unused fields of clear and free carry random values so their bits toggle too
  task automatic send_clear();
    send_word(word_of(sfc_pkg::CMD_CLEAR, sfc_pkg::OWNER_W'($urandom),
                      sfc_pkg::ADDR_W'($urandom), random_length(), 1'($urandom)));
  endtask

  task automatic send_free(input logic [sfc_pkg::OWNER_W-1:0] pid);
    send_word(word_of(sfc_pkg::CMD_FREE, pid, sfc_pkg::ADDR_W'($urandom), random_length(),
                      1'($urandom)));
  endtask

  task automatic send_append(input logic [sfc_pkg::OWNER_W-1:0] pid,
                             input logic [sfc_pkg::ADDR_W-1:0] base,
                             input logic [sfc_pkg::LEN_W-1:0] length, input logic occupied);
    send_word(word_of(sfc_pkg::CMD_APPEND, pid, base, length, occupied));
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // the block is already idle once its last result is taken; the extra wait is margin
    repeat (4) @(posedge clk);
  endtask

  // Change memory_size only while the block is idle
  task automatic write_mem_size(input logic [sfc_pkg::LEN_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    tbl_mem_size = value;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: check each accepted result word, then pick next ready
  // ---------------------------------------------------------------------------
  function automatic void flag_mismatch(input string field, input int want, input int got);
    fail_count++;
    $error("%s mismatch: expected %0d, got %0d", field, want, got);
  endfunction

  always @(posedge clk) begin
    seg_result_t want;
    // sampled values here are those before this edge, so this is the handshake
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        $error("result word with nothing pending: status %0d base %0d length %0d",
               out_status, out_merged_base, out_merged_length);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", int'(want.status), int'(out_status));
        if (out_merged_base !== want.merged_base)
          flag_mismatch("merged_base", int'(want.merged_base), int'(out_merged_base));
        if (out_merged_length !== want.merged_length)
          flag_mismatch("merged_length", int'(want.merged_length),
                        int'(out_merged_length));
      end
    end
    // stall the result side in random bursts
    if (steady) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Unused command, not-found on a fresh table, field extremes, length clamp
  task automatic test_commands();
    send_word(word_of(CMD_UNUSED, 8'hA5, 16'h5A5A, 17'h1_2345, 1'b1));
    send_free(8'h00);                                   // nothing busy yet
    send_append(8'hFF, 16'hFFFF, sfc_pkg::MEM_LIMIT, 1'b1);
    send_append(8'h00, 16'h0000, sfc_pkg::LEN_W'(1), 1'b0);
    send_free(8'hFF);                                   // both neighbors free: sum clamps
    send_append(8'h00, 16'h0000, sfc_pkg::LEN_W'(1), 1'b1);  // owner 0 may hold a segment
    send_free(8'h00);
    send_word(word_of(CMD_UNUSED, 8'h00, 16'h0000, sfc_pkg::LEN_W'(1), 1'b0));
  endtask

  // Free with no free neighbor, with both neighbors free, an unknown owner, and a repeat free
  task automatic test_coalescing();
    send_clear();
    send_append(8'd1, 16'd100, 17'd10, 1'b1);
    send_append(8'd2, 16'd110, 17'd20, 1'b1);
    send_append(8'd3, 16'd130, 17'd30, 1'b1);
    send_append(8'd4, 16'd160, 17'd40, 1'b0);
    send_free(8'd2);                                    // isolated
    send_free(8'd1);                                    // absorbs prev and next
    send_free(8'd5);                                    // unknown owner
    send_free(8'd3);                                    // collapses to one segment
    send_free(8'd2);                                    // already released
  endtask

  // Clear under each memory_size extreme; the merged length exposes the size used
  task automatic test_memory_size();
    logic [sfc_pkg::LEN_W-1:0] sizes[5];
    sizes[0] = '0;
    sizes[1] = {sfc_pkg::LEN_W{1'b1}};                  // above the address space: clamps
    sizes[2] = sfc_pkg::LEN_W'(1);
    sizes[3] = sfc_pkg::LEN_W'($urandom_range(2, 65535));
    sizes[4] = sfc_pkg::MEM_LIMIT;
    foreach (sizes[i]) begin
      write_mem_size(sizes[i]);
      send_clear();
      send_append(8'h42, 16'h1234, 17'd3, 1'b1);
      send_free(8'h42);
    end
  endtask

  // Fill every slot, bounce off the limit, free one (busy neighbors: no slot opens), bounce again
  task automatic test_table_full();
    send_clear();
    for (int k = 1; k < sfc_pkg::MAX_SEGMENTS; k++)
      send_append(sfc_pkg::OWNER_W'(k), sfc_pkg::ADDR_W'($urandom),
                  sfc_pkg::LEN_W'($urandom_range(1, 256)), 1'b1);
    send_append(8'hEE, sfc_pkg::ADDR_W'($urandom), random_length(), 1'b1);
    send_free(8'd7);
    send_append(8'hEE, sfc_pkg::ADDR_W'($urandom), random_length(), 1'b1);
    send_append(8'hEF, sfc_pkg::ADDR_W'($urandom), random_length(), 1'b0);
  endtask

  // Mostly well-formed rounds (clear, appends, frees from a small owner pool)
  // with some raw noise; memory_size changes and full drains come in between.
  task automatic test_random_traffic();
    logic [sfc_pkg::OWNER_W-1:0] pool[POOL_SIZE];
    int n_append, n_free, round, stop_at;
    round   = 0;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      round++;
      steady = ($urandom_range(0, 7) == 0);
      if (round % 12 == 0) write_mem_size(random_mem_size());
      else if (round % 12 == 6) wait_drained();
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 10)) send_word(random_word());
      end else begin
        foreach (pool[i]) pool[i] = sfc_pkg::OWNER_W'($urandom);
        send_clear();
        // now and then run past the table limit
        n_append = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 34)
                                               : $urandom_range(1, 12);
        repeat (n_append)
          send_append(pool[$urandom_range(0, POOL_SIZE-1)], sfc_pkg::ADDR_W'($urandom),
                      random_length(), ($urandom_range(0, 3) != 0));
        n_free = $urandom_range(1, n_append + 2);
        repeat (n_free) begin
          if ($urandom_range(0, 4) == 0)
            send_append(pool[$urandom_range(0, POOL_SIZE-1)], sfc_pkg::ADDR_W'($urandom),
                        random_length(), 1'($urandom));
          else if ($urandom_range(0, 7) == 0)
            send_free(sfc_pkg::OWNER_W'($urandom));
          else
            send_free(pool[$urandom_range(0, POOL_SIZE-1)]);
        end
      end
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, run sequence, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    tbl_mem_size = sfc_pkg::MEM_SIZE_RESET;
    table_clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_commands();
    test_coalescing();
    test_memory_size();
    test_table_full();
    test_random_traffic();

    // hold off until all results are back, then watch for strays over a full free
    wait_drained();
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
